// File: rtl/core/gfcp_pkg.sv
// Package with shared constants and types of the frame cache policy block.
package gfcp_pkg;
   localparam int FrameSlots = 4096;
   localparam int GroupSlots = 8;
   localparam int HandleBits = 16;
   localparam int FrameIdxBits = $clog2(FrameSlots);
   localparam int GroupIdxBits = $clog2(GroupSlots);
   localparam int EntryBits = 32 + 1 + 1 + HandleBits;

   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [3:0] ST_DISABLED = 4'd0;
   localparam logic [3:0] ST_NOKEY    = 4'd1;
   localparam logic [3:0] ST_AUDIO    = 4'd2;
   localparam logic [3:0] ST_CACHED   = 4'd3;
   localparam logic [3:0] ST_EVICTED  = 4'd4;
   localparam logic [3:0] ST_FLUSHED  = 4'd5;
   localparam logic [3:0] ST_READ_OK  = 4'd6;
   localparam logic [3:0] ST_READ_OOR = 4'd7;
   localparam logic [3:0] ST_CLEARED  = 4'd8;

   localparam logic [2:0] CSR_ENABLE = 3'd0;
   localparam logic [2:0] CSR_KEEP   = 3'd1;
   localparam logic [2:0] CSR_MAXT   = 3'd2;
   localparam logic [2:0] CSR_MAXV   = 3'd3;
   localparam logic [2:0] CSR_MAXA   = 3'd4;

   typedef struct packed {
      logic [31:0]           timestamp;
      logic                  is_video;
      logic                  is_key;
      logic [HandleBits-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic        enable;
      logic [2:0]  keep_gops;
      logic [11:0] max_total;
      logic [11:0] max_video;
      logic [11:0] max_audio;
   } cfg_type;
endpackage

// File: rtl/core/gfcp_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
interface gfcp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        is_video;
   logic        is_key;
   logic [31:0] timestamp;
   logic [15:0] payload_handle;
   logic [11:0] read_index;
   modport source (output valid, kind, is_video, is_key, timestamp, payload_handle,
                   read_index, input ready);
   modport sink (input valid, kind, is_video, is_key, timestamp, payload_handle,
                 read_index, output ready);
endinterface

interface gfcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [2:0]  group_count;
   logic [11:0] video_total;
   logic [11:0] audio_total;
   logic [31:0] rd_timestamp;
   logic        rd_is_video;
   logic        rd_is_key;
   logic [15:0] rd_handle;
   modport source (output valid, status, group_count, video_total, audio_total,
                   rd_timestamp, rd_is_video, rd_is_key, rd_handle, input ready);
   modport sink (input valid, status, group_count, video_total, audio_total,
                 rd_timestamp, rd_is_video, rd_is_key, rd_handle, output ready);
endinterface

interface gfcp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/gfcp_ring.sv
// Frame ring memory: one write port, one registered read port.
module gfcp_ring (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [gfcp_pkg::FrameIdxBits-1:0] wr_addr,
   input  gfcp_pkg::entry_type               wr_data,
   input  logic [gfcp_pkg::FrameIdxBits-1:0] rd_addr,
   output gfcp_pkg::entry_type               rd_data
);
   import gfcp_pkg::*;

   entry_type mem [FrameSlots];

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/core/gop_frame_cache_policy_top.sv
// Top level of the frame cache policy block: control sequencer and group table.
//
// Usage: requests arrive on req_ (push a frame, read an entry by age, clear).
// Each request gives exactly one transaction on rsp_ with status, the group
// count, the cached video and audio totals, and for a read the stored entry.
// Registers are written on csr_ (index 0 enable, 1 keep_gops, 2 total limit,
// 3 video limit, 4 audio limit); the user must do so only while the block is
// idle, as the block does not enforce it; csr_ready is always high.
// Sequence: a cached push passes link, limit check, eviction check and result;
// a flushing push skips the eviction check; an evicting push loops once per
// evicted group, walking the group table one entry per cycle. A read passes
// ring access and result; a clear, dropped push or unused kind goes to result.
// One request is in work at a time; req_ready goes high again in the cycle
// after the response transaction, so a stalled receiver holds the block after
// its single pending response. Reset empties the cache (head, count, group
// pointers and totals); the ring memory and group table are not cleared, as
// entries are only read below the live count.
module gop_frame_cache_policy_top (
   input logic       clock,
   input logic       reset,
   gfcp_req_if.sink  req,
   gfcp_rsp_if.source rsp,
   gfcp_csr_if.sink  csr
);
   import gfcp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PUSH  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_EVICT = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   cfg_type    cfg_ff;

   logic [FrameIdxBits-1:0] head_ff;
   logic [FrameIdxBits:0]   count_ff;
   logic [GroupIdxBits-1:0] oldest_ff;
   logic [GroupIdxBits:0]   live_ff;
   logic [12:0]             vsum_ff, asum_ff;

   logic [12:0]             gvid [GroupSlots];
   logic [12:0]             gaud [GroupSlots];

   logic        r_video_ff, r_key_ff;
   logic [31:0] r_ts_ff;
   logic [15:0] r_handle_ff;
   logic [11:0] r_idx_ff;

   logic        rsp_valid_ff;
   logic [3:0]  rsp_status_ff;
   logic        rsp_rd_ff;

   logic        ring_we;
   logic [FrameIdxBits-1:0] ring_waddr, ring_raddr;
   entry_type   ring_wdata, ring_rdata;

   logic [FrameIdxBits-1:0] tail_pos;
   logic [GroupIdxBits-1:0] new_grp, tail_grp;
   logic [2:0]  keep_lim;
   logic [11:0] tmax;
   logic [12:0] tsum;
   logic [12:0] evict_n;
   logic        push_drop;
   logic        flush_hit;

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   assign tail_pos  = head_ff + count_ff[FrameIdxBits-1:0];
   assign new_grp   = oldest_ff + live_ff[GroupIdxBits-1:0];
   assign tail_grp  = oldest_ff + live_ff[GroupIdxBits-1:0] - 1'b1;
   assign keep_lim  = cfg_ff.keep_gops;
   assign tmax      = (cfg_ff.max_total > 12'(FrameSlots - 1)) ? 12'(FrameSlots - 1)
                                                                : cfg_ff.max_total;
   assign tsum      = vsum_ff + asum_ff;
   assign evict_n   = ((gvid[oldest_ff] + gaud[oldest_ff]) > 13'(count_ff))
                      ? 13'(count_ff) : (gvid[oldest_ff] + gaud[oldest_ff]);

   // A push is dropped when disabled, when it is non-key video without a group,
   // or when it is audio while no video is cached.
   assign push_drop = !cfg_ff.enable || (req.is_video && !req.is_key && live_ff == '0) ||
                      (!req.is_video && vsum_ff == '0);
   // Any count above its limit flushes the whole cache.
   assign flush_hit = (vsum_ff > {1'b0, cfg_ff.max_video}) ||
                      (asum_ff > {1'b0, cfg_ff.max_audio}) || (tsum > {1'b0, tmax});

   // Ring port control: write in the push state, read address from the request.
   assign ring_we    = (state_ff == S_PUSH);
   assign ring_waddr = tail_pos;
   assign ring_wdata = '{timestamp: r_ts_ff, is_video: r_video_ff,
                         is_key: r_video_ff & r_key_ff, handle: r_handle_ff};
   assign ring_raddr = head_ff + r_idx_ff[FrameIdxBits-1:0];

   gfcp_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req.valid && req.ready) begin
            state_in = S_DONE;
            if (req.kind == KIND_PUSH && !push_drop) state_in = S_PUSH;
            else if (req.kind == KIND_READ) state_in = S_READ;
         end
         S_PUSH:  state_in = S_CHECK;
         S_CHECK: state_in = flush_hit ? S_DONE : S_EVICT;
         S_EVICT: if (!(live_ff > {1'b0, keep_lim})) state_in = S_DONE;
         S_READ:  state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enable: 1'b0, keep_gops: 3'd2, max_total: 12'd4095,
                     max_video: 12'd2048, max_audio: 12'd2048};
      end else if (csr.valid) begin
         case (csr.index)
            CSR_ENABLE: cfg_ff.enable    <= csr.data[0];
            CSR_KEEP:   cfg_ff.keep_gops <= csr.data[2:0];
            CSR_MAXT:   cfg_ff.max_total <= csr.data;
            CSR_MAXV:   cfg_ff.max_video <= csr.data;
            CSR_MAXA:   cfg_ff.max_audio <= csr.data;
            default: ;
         endcase
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         r_video_ff  <= req.is_video;
         r_key_ff    <= req.is_key;
         r_ts_ff     <= req.timestamp;
         r_handle_ff <= req.payload_handle;
         r_idx_ff    <= req.read_index;
      end
   end

   // Group table, written only in the push state.
   always_ff @(posedge clock) begin
      if (state_ff == S_PUSH) begin
         if (r_video_ff && r_key_ff) begin
            gvid[new_grp]   <= 13'(r_video_ff);
            gaud[new_grp]   <= 13'd0;
         end else if (r_video_ff) begin
            gvid[tail_grp]  <= gvid[tail_grp] + 13'd1;
         end else begin
            gaud[tail_grp]  <= gaud[tail_grp] + 13'd1;
         end
      end
   end

   // Main control: decide, link, check limits, evict, read, respond.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         oldest_ff    <= '0;
         live_ff      <= '0;
         vsum_ff      <= '0;
         asum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_status_ff <= ST_DISABLED;
         rsp_rd_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               rsp_rd_ff  <= 1'b0;
               if (req.valid && req.ready) begin
                  if (req.kind == KIND_CLEAR) begin
                     head_ff <= '0; count_ff <= '0; oldest_ff <= '0;
                     live_ff <= '0; vsum_ff <= '0; asum_ff <= '0;
                     rsp_status_ff <= ST_CLEARED;
                  end else if (req.kind == KIND_PUSH) begin
                     if (!cfg_ff.enable) begin
                        rsp_status_ff <= ST_DISABLED;
                     end else if (req.is_video && !req.is_key && live_ff == '0) begin
                        rsp_status_ff <= ST_NOKEY;
                     end else if (!req.is_video && vsum_ff == '0) begin
                        rsp_status_ff <= ST_AUDIO;
                     end
                  end else if (req.kind != KIND_READ) begin
                     rsp_status_ff <= ST_READ_OOR;
                  end
               end
            end
            S_PUSH: begin
               count_ff <= count_ff + 1'b1;
               if (r_video_ff) vsum_ff <= vsum_ff + 13'd1;
               else asum_ff <= asum_ff + 13'd1;
               if (r_video_ff && r_key_ff) live_ff <= live_ff + 1'b1;
            end
            S_CHECK: begin
               if (flush_hit) begin
                  head_ff <= '0; count_ff <= '0; oldest_ff <= '0;
                  live_ff <= '0; vsum_ff <= '0; asum_ff <= '0;
                  rsp_status_ff <= ST_FLUSHED;
               end else begin
                  rsp_status_ff <= ST_CACHED;
               end
            end
            S_EVICT: begin
               if (live_ff > {1'b0, keep_lim}) begin
                  head_ff   <= head_ff + evict_n[FrameIdxBits-1:0];
                  count_ff  <= count_ff - evict_n;
                  vsum_ff   <= (gvid[oldest_ff] > vsum_ff) ? 13'd0
                               : vsum_ff - gvid[oldest_ff];
                  asum_ff   <= (gaud[oldest_ff] > asum_ff) ? 13'd0
                               : asum_ff - gaud[oldest_ff];
                  oldest_ff <= oldest_ff + 1'b1;
                  live_ff   <= live_ff - 1'b1;
                  rsp_status_ff <= ST_EVICTED;
               end
            end
            S_READ: begin
               if ({1'b0, r_idx_ff} < count_ff) begin
                  rsp_status_ff <= ST_READ_OK;
                  rsp_rd_ff <= 1'b1;
               end else begin
                  rsp_status_ff <= ST_READ_OOR;
               end
            end
            S_DONE: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // Response register; read fields come from the registered ring output.
   logic [31:0] rd_ts_ff;
   logic        rd_vid_ff, rd_key_ff;
   logic [15:0] rd_h_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         rd_ts_ff  <= rsp_rd_ff ? ring_rdata.timestamp : 32'd0;
         rd_vid_ff <= rsp_rd_ff & ring_rdata.is_video;
         rd_key_ff <= rsp_rd_ff & ring_rdata.is_key;
         rd_h_ff   <= rsp_rd_ff ? ring_rdata.handle : 16'd0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.group_count  = live_ff[2:0];
   assign rsp.video_total  = vsum_ff[11:0];
   assign rsp.audio_total  = asum_ff[11:0];
   assign rsp.rd_timestamp = rd_ts_ff;
   assign rsp.rd_is_video  = rd_vid_ff;
   assign rsp.rd_is_key    = rd_key_ff;
   assign rsp.rd_handle    = rd_h_ff;

   // The live group count never exceeds the table.
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= (GroupIdxBits+1)'(GroupSlots)) else $error("group count overflow");
   // The ring count never exceeds the ring.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FrameIdxBits+1)'(FrameSlots)) else $error("ring count overflow");
   // No request is taken while a response waits.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready) else $error("request taken with pending response");
   // Eviction finishes with at most keep groups.
   a_evict_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVICT && state_in == S_DONE) |-> live_ff <= {1'b0, keep_lim})
      else $error("eviction left too many groups");
endmodule

// File: verif/testbench.sv
// Self-checking testbench for the frame cache policy block with a built-in cache predictor.
`timescale 1ns / 1ps

module testbench;
   import gfcp_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      logic        is_video;
      logic        is_key;
      logic [31:0] timestamp;
      logic [15:0] handle;
      logic [11:0] read_index;
   } frame_req_type;

   typedef struct {
      logic [3:0]  status;
      logic [2:0]  group_count;
      logic [11:0] video_total;
      logic [11:0] audio_total;
      logic [31:0] rd_timestamp;
      logic        rd_is_video;
      logic        rd_is_key;
      logic [15:0] rd_handle;
   } cache_rsp_type;

   typedef struct {
      logic          is_csr;
      logic [2:0]    csr_index;
      logic [11:0]   csr_data;
      frame_req_type req;
      logic          typed;
      cache_rsp_type rsp;
   } stim_row_type;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic clock;
   logic reset;

   gfcp_req_if req_ch ();
   gfcp_rsp_if rsp_ch ();
   gfcp_csr_if csr_ch ();

   gop_frame_cache_policy_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Predictor state: the frame ring, the group table and the settings.
   logic [31:0] ring_ts [FrameSlots];
   logic        ring_vid [FrameSlots];
   logic        ring_key [FrameSlots];
   logic [15:0] ring_handle [FrameSlots];
   int unsigned grp_video [GroupSlots];
   int unsigned grp_audio [GroupSlots];
   int unsigned head, count, oldest, live, video_sum, audio_sum;
   cfg_type     cfg;

   cache_rsp_type expected_rsp [$];
   int          errors;
   bit          calm;
   bit          long_hold;

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Overall time limit.
   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic void wipe_cache();
      head = 0;
      count = 0;
      oldest = 0;
      live = 0;
      video_sum = 0;
      audio_sum = 0;
   endfunction

   // Drops the oldest group and the frames that belong to it.
   function automatic void drop_oldest_group();
      int unsigned g;
      int unsigned n;
      g = oldest % GroupSlots;
      n = grp_video[g] + grp_audio[g];
      if (n > count) n = count;
      head = (head + n) % FrameSlots;
      count -= n;
      video_sum -= (grp_video[g] > video_sum) ? video_sum : grp_video[g];
      audio_sum -= (grp_audio[g] > audio_sum) ? audio_sum : grp_audio[g];
      oldest = (g + 1) % GroupSlots;
      live--;
   endfunction

   // Applies one transaction to the predicted cache and returns its response.
   function automatic cache_rsp_type cache_predict(input frame_req_type r);
      cache_rsp_type o;
      int unsigned g, pos, tmax, keep;
      bit          evicted;
      o = '{default: '0};
      evicted = 0;
      case (r.kind)
         KIND_PUSH: begin
            if (!cfg.enable) o.status = ST_DISABLED;
            else if (r.is_video && !r.is_key && live == 0) o.status = ST_NOKEY;
            else if (!r.is_video && video_sum == 0) o.status = ST_AUDIO;
            else begin
               if (r.is_video && r.is_key) begin
                  g = (oldest + live) % GroupSlots;
                  grp_video[g] = 0;
                  grp_audio[g] = 0;
                  live++;
               end
               g = (oldest + live + GroupSlots - 1) % GroupSlots;
               pos = (head + count) % FrameSlots;
               ring_ts[pos] = r.timestamp;
               ring_vid[pos] = r.is_video;
               ring_key[pos] = r.is_video & r.is_key;
               ring_handle[pos] = r.handle;
               count++;
               if (r.is_video) begin
                  video_sum++;
                  grp_video[g]++;
               end else begin
                  audio_sum++;
                  grp_audio[g]++;
               end
               tmax = (cfg.max_total > FrameSlots - 1) ? FrameSlots - 1 : cfg.max_total;
               if (video_sum > cfg.max_video || audio_sum > cfg.max_audio ||
                   video_sum + audio_sum > tmax) begin
                  wipe_cache();
                  o.status = ST_FLUSHED;
               end else begin
                  keep = (cfg.keep_gops > GroupSlots - 1) ? GroupSlots - 1 : cfg.keep_gops;
                  while (live > keep) begin
                     drop_oldest_group();
                     evicted = 1;
                  end
                  o.status = evicted ? ST_EVICTED : ST_CACHED;
               end
            end
         end
         KIND_READ: begin
            if (r.read_index < count) begin
               pos = (head + r.read_index) % FrameSlots;
               o.status = ST_READ_OK;
               o.rd_timestamp = ring_ts[pos];
               o.rd_is_video = ring_vid[pos];
               o.rd_is_key = ring_key[pos];
               o.rd_handle = ring_handle[pos];
            end else begin
               o.status = ST_READ_OOR;
            end
         end
         KIND_CLEAR: begin
            wipe_cache();
            o.status = ST_CLEARED;
         end
         default: o.status = ST_READ_OOR;
      endcase
      o.group_count = live[2:0];
      o.video_total = video_sum[11:0];
      o.audio_total = audio_sum[11:0];
      return o;
   endfunction

   // Response checker: each accepted transaction against the oldest expectation.
   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp.size() == 0) begin
            report("unexpected response status", rsp_ch.status, '0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_ch.status !== want.status) report("status", rsp_ch.status, want.status);
            if (rsp_ch.group_count !== want.group_count)
               report("group_count", rsp_ch.group_count, want.group_count);
            if (rsp_ch.video_total !== want.video_total)
               report("video_total", rsp_ch.video_total, want.video_total);
            if (rsp_ch.audio_total !== want.audio_total)
               report("audio_total", rsp_ch.audio_total, want.audio_total);
            if (rsp_ch.rd_timestamp !== want.rd_timestamp)
               report("rd_timestamp", rsp_ch.rd_timestamp, want.rd_timestamp);
            if (rsp_ch.rd_is_video !== want.rd_is_video)
               report("rd_is_video", rsp_ch.rd_is_video, want.rd_is_video);
            if (rsp_ch.rd_is_key !== want.rd_is_key)
               report("rd_is_key", rsp_ch.rd_is_key, want.rd_is_key);
            if (rsp_ch.rd_handle !== want.rd_handle)
               report("rd_handle", rsp_ch.rd_handle, want.rd_handle);
         end
      end
   end

   // Response receiver: random stalls, and one long hold-off on request.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 5);
         if (long_hold) begin
            gap = 300;
            long_hold = 0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   // Sends one request transaction; typed expectations override the predictor.
   task automatic send_request(input frame_req_type r, input logic typed,
                               input cache_rsp_type typed_rsp);
      int            gap;
      cache_rsp_type want;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= r.kind;
      req_ch.is_video <= r.is_video;
      req_ch.is_key <= r.is_key;
      req_ch.timestamp <= r.timestamp;
      req_ch.payload_handle <= r.handle;
      req_ch.read_index <= r.read_index;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      want = cache_predict(r);
      expected_rsp.push_back(typed ? typed_rsp : want);
      @(negedge clock);
   endtask

   // Waits until every response is in and the block has settled.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes one register; the block must be idle.
   task automatic write_reg(input logic [2:0] index, input logic [11:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= data;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      case (index)
         CSR_ENABLE: cfg.enable = data[0];
         CSR_KEEP:   cfg.keep_gops = data[2:0];
         CSR_MAXT:   cfg.max_total = data;
         CSR_MAXV:   cfg.max_video = data;
         CSR_MAXA:   cfg.max_audio = data;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic stim_row_type req_row(input logic [1:0] kind, input logic vid,
                                            input logic key, input logic [31:0] ts,
                                            input logic [15:0] h, input logic [11:0] idx);
      stim_row_type s;
      s = '{default: '0};
      s.req = '{kind, vid, key, ts, h, idx};
      return s;
   endfunction

   function automatic stim_row_type csr_row(input logic [2:0] index, input logic [11:0] data);
      stim_row_type s;
      s = '{default: '0};
      s.is_csr = 1;
      s.csr_index = index;
      s.csr_data = data;
      return s;
   endfunction

   function automatic stim_row_type typed_row(input stim_row_type s, input logic [3:0] st,
                                              input logic [2:0] g, input logic [11:0] v,
                                              input logic [11:0] a);
      s.typed = 1;
      s.rsp = '{st, g, v, a, 32'd0, 1'b0, 1'b0, 16'd0};
      return s;
   endfunction

   // Draws one random request, mostly well-formed pushes of video groups.
   function automatic frame_req_type random_request();
      frame_req_type r;
      int            pick;
      r.timestamp = $urandom();
      r.handle = 16'($urandom_range(0, 65535));
      r.read_index = 12'($urandom_range(0, 4095));
      r.is_video = 1'($urandom_range(0, 1));
      r.is_key = 1'($urandom_range(0, 1));
      r.kind = KIND_PUSH;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         r.is_video = 1;
         r.is_key = 1;
      end else if (pick < 50) begin
         r.is_video = 1;
         r.is_key = 0;
      end else if (pick < 75) begin
         r.is_video = 0;
      end else if (pick < 95) begin
         r.kind = KIND_READ;
         if ($urandom_range(0, 3) != 0) r.read_index = 12'($urandom_range(0, count + 1));
      end else if (pick < 98) begin
         r.kind = KIND_CLEAR;
      end else begin
         r.kind = KIND_UNUSED;
      end
      return r;
   endfunction

   function automatic logic [11:0] random_limit();
      case ($urandom_range(0, 5))
         0: return 12'd4095;
         1: return 12'd1;
         2: return 12'd0;
         3: return 12'($urandom_range(2, 40));
         default: return 12'($urandom_range(40, 4095));
      endcase
   endfunction

   // Main sequence: reset, directed rows, then randomized phases.
   initial begin
      stim_row_type  rows [$];
      cache_rsp_type none;
      int            phase;
      int            n;
      none = '{default: '0};
      errors = 0;
      calm = 0;
      long_hold = 0;
      cfg = '{1'b0, 3'd2, 12'd4095, 12'd2048, 12'd2048};
      wipe_cache();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_PUSH;
      req_ch.is_video = 1'b0;
      req_ch.is_key = 1'b0;
      req_ch.timestamp = '0;
      req_ch.payload_handle = '0;
      req_ch.read_index = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_ENABLE;
      csr_ch.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: disabled drops, drops without a group, extremes, eviction, flush.
      rows.push_back(typed_row(req_row(KIND_PUSH, 1, 1, 32'hFFFF_FFFF, 16'hFFFF, 0),
                               ST_DISABLED, 0, 0, 0));
      rows.push_back(typed_row(req_row(KIND_READ, 0, 0, 0, 0, 12'd0), ST_READ_OOR, 0, 0, 0));
      rows.push_back(typed_row(req_row(KIND_UNUSED, 1, 1, 0, 0, 0), ST_READ_OOR, 0, 0, 0));
      rows.push_back(typed_row(req_row(KIND_CLEAR, 0, 0, 0, 0, 0), ST_CLEARED, 0, 0, 0));
      rows.push_back(csr_row(CSR_ENABLE, 12'd1));
      rows.push_back(typed_row(req_row(KIND_PUSH, 1, 0, 32'd5, 16'd1, 0), ST_NOKEY, 0, 0, 0));
      rows.push_back(typed_row(req_row(KIND_PUSH, 0, 1, 32'd6, 16'd2, 0), ST_AUDIO, 0, 0, 0));
      rows.push_back(typed_row(req_row(KIND_PUSH, 1, 1, 32'hFFFF_FFFF, 16'hFFFF, 0),
                               ST_CACHED, 1, 1, 0));
      rows.push_back(req_row(KIND_PUSH, 0, 1, 32'd0, 16'd0, 0));
      rows.push_back(req_row(KIND_READ, 0, 0, 0, 0, 12'd0));
      rows.push_back(req_row(KIND_READ, 0, 0, 0, 0, 12'd1));
      rows.push_back(typed_row(req_row(KIND_READ, 0, 0, 0, 0, 12'hFFF), ST_READ_OOR, 1, 1, 1));
      rows.push_back(req_row(KIND_PUSH, 1, 1, 32'd0, 16'd0, 0));
      rows.push_back(req_row(KIND_PUSH, 1, 0, 32'h8000_0000, 16'h8000, 0));
      rows.push_back(req_row(KIND_PUSH, 1, 1, 32'd100, 16'h1234, 0));
      rows.push_back(req_row(KIND_READ, 0, 0, 0, 0, 12'd0));
      rows.push_back(csr_row(CSR_KEEP, 12'd0));
      rows.push_back(req_row(KIND_PUSH, 1, 1, 32'd200, 16'h00FF, 0));
      rows.push_back(csr_row(CSR_KEEP, 12'd7));
      rows.push_back(csr_row(CSR_MAXV, 12'd1));
      rows.push_back(req_row(KIND_PUSH, 1, 1, 32'd300, 16'd3, 0));
      rows.push_back(req_row(KIND_PUSH, 1, 0, 32'd301, 16'd4, 0));
      rows.push_back(csr_row(CSR_MAXV, 12'd2048));
      rows.push_back(csr_row(CSR_MAXT, 12'd0));
      rows.push_back(csr_row(CSR_MAXA, 12'd4095));
      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            wait_idle();
            write_reg(rows[i].csr_index, rows[i].csr_data);
         end else begin
            send_request(rows[i].req, rows[i].typed, rows[i].rsp);
         end
      end

      // Random phases, each with its own register setting.
      for (phase = 0; phase < 9; phase++) begin
         wait_idle();
         calm = (phase % 3 == 2);
         if (phase == 0) begin
            write_reg(CSR_MAXT, 12'd4095);
            write_reg(CSR_MAXV, 12'd4095);
            write_reg(CSR_MAXA, 12'd4095);
            write_reg(CSR_KEEP, 12'd7);
         end else begin
            write_reg(CSR_ENABLE, ($urandom_range(0, 7) != 0) ? 12'd1 : 12'd0);
            write_reg(CSR_KEEP, 12'($urandom_range(0, 7)));
            write_reg(CSR_MAXT, random_limit());
            write_reg(CSR_MAXV, random_limit());
            write_reg(CSR_MAXA, random_limit());
         end
         if (phase == 4) long_hold = 1;
         for (n = 0; n < 55; n++) send_request(random_request(), 1'b0, none);
      end

      // Drain with a bound, then settle.
      req_ch.valid <= 1'b0;
      n = 0;
      while (expected_rsp.size() != 0 && n < 5000) begin
         @(posedge clock);
         n++;
      end
      repeat (20) @(posedge clock);
      if (expected_rsp.size() != 0)
         report("responses never arrived", expected_rsp.size(), '0);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
